>>> rtl/atl_pkg.sv
`default_nettype none

package atl_pkg;

    localparam int FIELD_W  = 16;
    localparam int CHAR_W   = 8;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;

    typedef enum logic [2:0] {
        KIND_EOL     = 3'd0,
        KIND_INTEGER = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_LABEL   = 3'd3,
        KIND_EOF     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDENT,
        ST_INTEGER,
        ST_HEX,
        ST_LABEL,
        ST_COMMENT
    } t_scan;

    // results of one byte: a token, optionally followed by an end of line
    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] eol_start;
        logic               two;
    } t_rec;

    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic               last;
    } t_token;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'h00;
        if (is_digit(c)) begin
            d = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/atl_front.sv
`default_nettype none

module atl_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [atl_pkg::CHAR_W-1:0]  i_char,
    input  wire                         i_full,
    output logic                        o_push,
    output atl_pkg::t_rec               o_rec
);
    import atl_pkg::*;

    t_scan              r_state, n_state;
    logic [FIELD_W-1:0] r_pos, n_pos;
    logic [FIELD_W-1:0] r_start, n_start;
    logic [FIELD_W-1:0] r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_line, n_line;
    logic [FIELD_W-1:0] r_acc, n_acc;

    logic accept;
    logic close;
    logic rescan;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_cnt   <= '0;
            r_line  <= FIELD_W'(1);
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_line  <= n_line;
            r_acc   <= n_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_line  = r_line;
        n_acc   = r_acc;
        close   = 1'b0;
        rescan  = 1'b0;
        o_push  = 1'b0;
        o_rec   = '0;
        if (accept) begin
            if (i_char == CH_NUL) begin
                o_rec.kind  = KIND_EOF;
                o_rec.start = r_pos;
                o_rec.line  = r_line;
                o_push      = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                case (r_state)
                    ST_IDENT, ST_LABEL: begin
                        if (is_digit(i_char) || is_letter(i_char)) begin
                            n_pos = r_pos + 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            close  = 1'b1;
                            rescan = 1'b1;
                        end
                    end
                    ST_INTEGER: begin
                        if (is_digit(i_char)) begin
                            n_acc = (r_acc << 3) + (r_acc << 1)
                                  + FIELD_W'(i_char - 8'h30);
                            n_pos = r_pos + 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            close  = 1'b1;
                            rescan = 1'b1;
                        end
                    end
                    ST_HEX: begin
                        if (is_hex(i_char)) begin
                            n_acc = {r_acc[FIELD_W-5:0], hex_val(i_char)};
                            n_pos = r_pos + 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            close  = 1'b1;
                            rescan = 1'b1;
                        end
                    end
                    ST_COMMENT: begin
                        if (i_char != CH_LF) begin
                            n_pos = r_pos + 1'b1;
                        end else begin
                            rescan = 1'b1;
                        end
                    end
                    default: begin
                        rescan = 1'b1;
                    end
                endcase

                if (close) begin
                    case (r_state)
                        ST_IDENT: o_rec.kind = KIND_IDENT;
                        ST_LABEL: o_rec.kind = KIND_LABEL;
                        default:  o_rec.kind = KIND_INTEGER;
                    endcase
                    o_rec.value  = ((r_state == ST_INTEGER) || (r_state == ST_HEX)) ?
                                   r_acc : '0;
                    o_rec.start  = r_start;
                    o_rec.length = r_cnt;
                    o_rec.line   = r_line;
                    o_push       = 1'b1;
                end

                if (rescan) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                    n_start = r_pos;
                    n_pos   = r_pos + 1'b1;
                    if (is_letter(i_char)) begin
                        n_cnt   = FIELD_W'(1);
                        n_state = ST_IDENT;
                    end else if (is_digit(i_char)) begin
                        n_cnt   = FIELD_W'(1);
                        n_acc   = FIELD_W'(i_char - 8'h30);
                        n_state = ST_INTEGER;
                    end else if (i_char == CH_LF) begin
                        n_cnt  = FIELD_W'(1);
                        n_line = r_line + 1'b1;
                        o_push = 1'b1;
                        if (close) begin
                            o_rec.two       = 1'b1;
                            o_rec.eol_start = r_pos;
                        end else begin
                            o_rec.kind   = KIND_EOL;
                            o_rec.value  = '0;
                            o_rec.start  = r_pos;
                            o_rec.length = FIELD_W'(1);
                            o_rec.line   = r_line;
                        end
                    end else if (i_char == CH_AT) begin
                        n_acc   = '0;
                        n_start = r_pos + 1'b1;
                        n_state = ST_LABEL;
                    end else if (i_char == CH_DOLLAR) begin
                        n_acc   = '0;
                        n_state = ST_HEX;
                    end else if (i_char == CH_SEMI) begin
                        n_state = ST_COMMENT;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_eof_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_char == CH_NUL)) |=> (r_state == ST_IDLE && $stable(r_pos)))
        else $error("end of input left scanner busy or moved offset");

    a_line_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && (i_char == CH_LF)) |=> $stable(r_line))
        else $error("line counter moved without newline");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/atl_queue.sv
`default_nettype none

module atl_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  atl_pkg::t_rec   i_rec,
    output logic            o_full,
    input  wire             i_pop,
    output atl_pkg::t_rec   o_rec,
    output logic            o_empty
);
    import atl_pkg::*;

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/atl_back.sv
`default_nettype none

module atl_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  atl_pkg::t_rec   i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  wire             i_ready,
    output atl_pkg::t_token o_token
);
    import atl_pkg::*;

    logic               r_valid, n_valid;
    logic               r_pend, n_pend;
    t_token             r_tok, n_tok;
    logic [FIELD_W-1:0] r_pend_start, n_pend_start;
    logic [FIELD_W-1:0] r_pend_line, n_pend_line;
    logic               load;

    assign o_valid = r_valid;
    assign o_token = r_tok;
    assign load    = !r_valid || i_ready;

    always_comb begin
        n_valid      = r_valid;
        n_pend       = r_pend;
        n_tok        = r_tok;
        n_pend_start = r_pend_start;
        n_pend_line  = r_pend_line;
        o_pop        = 1'b0;
        if (load) begin
            if (r_pend) begin
                // trailing end of line from the same byte
                n_tok.kind   = KIND_EOL;
                n_tok.value  = '0;
                n_tok.start  = r_pend_start;
                n_tok.length = FIELD_W'(1);
                n_tok.line   = r_pend_line;
                n_tok.last   = 1'b1;
                n_valid      = 1'b1;
                n_pend       = 1'b0;
            end else if (!i_empty) begin
                o_pop        = 1'b1;
                n_tok.kind   = i_rec.kind;
                n_tok.value  = i_rec.value;
                n_tok.start  = i_rec.start;
                n_tok.length = i_rec.length;
                n_tok.line   = i_rec.line;
                n_tok.last   = !i_rec.two;
                n_valid      = 1'b1;
                n_pend       = i_rec.two;
                n_pend_start = i_rec.eol_start;
                n_pend_line  = i_rec.line;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok        <= n_tok;
        r_pend_start <= n_pend_start;
        r_pend_line  <= n_pend_line;
    end

`ifndef SYNTHESIS
    a_pend_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && !r_tok.last))
        else $error("pending end of line without its first token");
`endif

endmodule

`default_nettype wire

>>> rtl/assembler_token_lexer_core.sv
// assembler token scanner
// slave channel: one source byte per transfer in s_tdata; byte 0 ends the
// input, byte 10 is a newline. master channel: one token per transfer,
// kind in m_tuser, value/start/length/line in m_tdata, m_tlast on the
// final token that a byte causes (a byte gives none, one or two tokens).
// a byte is taken every cycle while the four-entry token queue has room;
// s_tready falls only when the queue is full.
// path: a token is written into the queue when the byte that causes it is
// taken, then loaded into the output register and offered on the master
// channel; a trailing end of line follows as the next output token.
// throughput: one byte per cycle in while the queue has room, one token
// per cycle out while the receiver is ready; a newline that closes a token gives two.
// when the receiver stalls the output register holds its token and the
// queue fills, after which the input channel is held off.
// reset clears the scan state, offsets and queue; the line counter
// restarts at one.
`default_nettype none

module assembler_token_lexer_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    input  wire  [atl_pkg::CHAR_W-1:0]  i_s_tdata,   // char_code
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [4*atl_pkg::FIELD_W-1:0] o_m_tdata, // value, start, length, line
    output logic [2:0]                  o_m_tuser,   // token_kind
    output logic                        o_m_tlast    // last_of_run
);
    import atl_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    t_rec   front_rec;
    t_rec   head_rec;
    t_token tok;

    atl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_char  (i_s_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    atl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_empty (empty)
    );

    atl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_rec   (head_rec),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_token (tok)
    );

    assign o_m_tdata = {tok.line, tok.length, tok.start, tok.value};
    assign o_m_tuser = tok.kind;
    assign o_m_tlast = tok.last;

endmodule

`default_nettype wire
